// ----- rtl/pfpu_pkg.sv -----
package pfpu_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int PROD_W  = 2 * FIELD_W;

  // result kinds
  localparam logic [1:0] KIND_PIXEL     = 2'd0;
  localparam logic [1:0] KIND_BAD_DEPTH = 2'd1;
  localparam logic [1:0] KIND_EMPTY     = 2'd2;

  // header byte positions
  localparam logic [2:0] HDR_ROWS_HI  = 3'd0;
  localparam logic [2:0] HDR_ROWS_LO  = 3'd1;
  localparam logic [2:0] HDR_COLS_HI  = 3'd2;
  localparam logic [2:0] HDR_COLS_LO  = 3'd3;
  localparam logic [2:0] HDR_DEPTH_HI = 3'd6;
  localparam logic [2:0] HDR_DEPTH_LO = 3'd7;

  typedef enum logic [4:0] {
    ST_HDR  = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_STAT = 5'b00100,
    ST_DATA = 5'b01000,
    ST_PIX  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } unp_ctrl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              last;
  } unp_stat_t;

  function automatic logic depth_ok(input logic [FIELD_W-1:0] d);
    return (d == 16'd1) || (d == 16'd2) || (d == 16'd4) || (d == 16'd8);
  endfunction

  // log2 of a legal depth
  function automatic logic [1:0] depth_lg(input logic [FIELD_W-1:0] d);
    logic [1:0] lg;
    lg = 2'd0;
    if (d[1]) lg = 2'd1;
    if (d[2]) lg = 2'd2;
    if (d[3]) lg = 2'd3;
    return lg;
  endfunction

endpackage

// ----- rtl/pfpu_mult.sv -----
module pfpu_mult (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [pfpu_pkg::FIELD_W-1:0]        a,
  input  logic [pfpu_pkg::FIELD_W-1:0]        b,
  output logic                                done,
  output logic [pfpu_pkg::PROD_W-1:0]         product
);

  logic [pfpu_pkg::FIELD_W-1:0] mcand_r;
  logic [pfpu_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [pfpu_pkg::FIELD_W:0]   sum;

  // shift-and-add, one multiplier bit per cycle
  always_comb begin
    sum      = {1'b0, prod_r[pfpu_pkg::PROD_W-1:pfpu_pkg::FIELD_W]};
    if (prod_r[0]) begin
      sum = sum + {1'b0, mcand_r};
    end
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = {{pfpu_pkg::FIELD_W{1'b0}}, b};
      cnt_nxt  = 5'd16;
    end else if (cnt_r != 5'd0) begin
      prod_nxt = {sum, prod_r[pfpu_pkg::FIELD_W-1:1]};
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (start) begin
      mcand_r <= a;
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

// ----- rtl/pfpu_unpack.sv -----
module pfpu_unpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfpu_pkg::unp_ctrl_t           ctrl,
  input  logic [pfpu_pkg::BYTE_W-1:0]   byte_in,
  input  logic [1:0]                    lg_in,
  output pfpu_pkg::unp_stat_t           stat
);

  logic [pfpu_pkg::BYTE_W-1:0] sr_r, sr_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic [1:0]                  lg_r;

  always_comb begin
    sr_nxt  = sr_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      sr_nxt  = byte_in;
      cnt_nxt = 4'd8 >> lg_in;
    end else if (ctrl.step) begin
      case (lg_r)
        2'd0:    sr_nxt = {sr_r[6:0], 1'b0};
        2'd1:    sr_nxt = {sr_r[5:0], 2'b0};
        2'd2:    sr_nxt = {sr_r[3:0], 4'b0};
        default: sr_nxt = '0;
      endcase
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (ctrl.load) begin
      lg_r <= lg_in;
    end
  end

  // most significant digit first, zero extended
  always_comb begin
    case (lg_r)
      2'd0:    stat.pixel = {7'b0, sr_r[7]};
      2'd1:    stat.pixel = {6'b0, sr_r[7:6]};
      2'd2:    stat.pixel = {4'b0, sr_r[7:4]};
      default: stat.pixel = sr_r;
    endcase
    stat.last = (cnt_r == 4'd1);
  end

endmodule

// ----- rtl/packed_frame_pixel_unpacker.sv -----
// Header: 8 beats, then the row*column product is formed on a bit-serial
// multiplier (16 shift-add steps, then a done strobe) before data beats are taken
// (an empty-frame result follows it instead; a bad depth skips the product).
// Data: 8/bpp pixel results per data beat from a digit shift register, one per
// cycle while in_valid and out_ready keep up; each passes the output register.
// Reset (rst_n, synchronous, active low) returns to expecting a header.
module packed_frame_pixel_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_pixel_value,
  output logic        out_last_in_byte,
  output logic        out_last_in_frame,
  output logic [15:0] out_frame_width,
  output logic [15:0] out_frame_height,
  output logic [15:0] out_pixel_depth
);

  pfpu_pkg::state_t state_r, state_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic [15:0] cols_r, cols_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic        last_byte_r, last_byte_nxt;
  logic [1:0]  stat_kind_r, stat_kind_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  pix_r, pix_nxt;
  logic        lib_r, lib_nxt;
  logic        lif_r, lif_nxt;
  logic [15:0] ow_r, ow_nxt;
  logic [15:0] oh_r, oh_nxt;
  logic [15:0] od_r, od_nxt;

  logic        mul_start, mul_done;
  logic [31:0] mul_prod;
  logic [31:0] frame_bytes;
  logic        emit_ok;
  logic        out_load;

  pfpu_pkg::unp_ctrl_t unp_ctrl;
  pfpu_pkg::unp_stat_t unp_stat;

  pfpu_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (rows_r),
    .b       (cols_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  pfpu_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (unp_ctrl),
    .byte_in (in_data_byte),
    .lg_in   (pfpu_pkg::depth_lg(depth_r)),
    .stat    (unp_stat)
  );

  // rows*cols*bpp/8 with bpp a power of two
  always_comb begin
    case (pfpu_pkg::depth_lg(depth_r))
      2'd0:    frame_bytes = {3'b0, mul_prod[31:3]};
      2'd1:    frame_bytes = {2'b0, mul_prod[31:2]};
      2'd2:    frame_bytes = {1'b0, mul_prod[31:1]};
      default: frame_bytes = mul_prod;
    endcase
  end

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    hdr_idx_nxt    = hdr_idx_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    depth_nxt      = depth_r;
    bytes_left_nxt = bytes_left_r;
    last_byte_nxt  = last_byte_r;
    stat_kind_nxt  = stat_kind_r;
    in_ready       = 1'b0;
    mul_start      = 1'b0;
    unp_ctrl       = '0;
    out_load       = 1'b0;
    kind_nxt       = pfpu_pkg::KIND_PIXEL;
    pix_nxt        = unp_stat.pixel;
    lib_nxt        = 1'b0;
    lif_nxt        = 1'b1;

    unique case (state_r)
      pfpu_pkg::ST_HDR: begin
        in_ready = 1'b1;
        if (in_valid) begin
          hdr_idx_nxt = hdr_idx_r + 3'd1;
          case (hdr_idx_r)
            pfpu_pkg::HDR_ROWS_HI:  rows_nxt  = {in_data_byte, rows_r[7:0]};
            pfpu_pkg::HDR_ROWS_LO:  rows_nxt  = {rows_r[15:8], in_data_byte};
            pfpu_pkg::HDR_COLS_HI:  cols_nxt  = {in_data_byte, cols_r[7:0]};
            pfpu_pkg::HDR_COLS_LO:  cols_nxt  = {cols_r[15:8], in_data_byte};
            pfpu_pkg::HDR_DEPTH_HI: depth_nxt = {in_data_byte, depth_r[7:0]};
            pfpu_pkg::HDR_DEPTH_LO: depth_nxt = {depth_r[15:8], in_data_byte};
            default: ;
          endcase
          if (hdr_idx_r == pfpu_pkg::HDR_DEPTH_LO) begin
            if (pfpu_pkg::depth_ok(depth_nxt)) begin
              mul_start = 1'b1;
              state_nxt = pfpu_pkg::ST_MUL;
            end else begin
              stat_kind_nxt = pfpu_pkg::KIND_BAD_DEPTH;
              state_nxt     = pfpu_pkg::ST_STAT;
            end
          end
        end
      end
      pfpu_pkg::ST_MUL: begin
        if (mul_done) begin
          if (frame_bytes == 32'd0) begin
            stat_kind_nxt = pfpu_pkg::KIND_EMPTY;
            state_nxt     = pfpu_pkg::ST_STAT;
          end else begin
            bytes_left_nxt = frame_bytes;
            state_nxt      = pfpu_pkg::ST_DATA;
          end
        end
      end
      pfpu_pkg::ST_STAT: begin
        if (emit_ok) begin
          out_load  = 1'b1;
          kind_nxt  = stat_kind_r;
          pix_nxt   = 8'd0;
          state_nxt = pfpu_pkg::ST_HDR;
        end
      end
      pfpu_pkg::ST_DATA: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unp_ctrl.load = 1'b1;
          last_byte_nxt = (bytes_left_r[31:1] == 31'd0);
          state_nxt     = pfpu_pkg::ST_PIX;
        end
      end
      pfpu_pkg::ST_PIX: begin
        if (emit_ok) begin
          out_load      = 1'b1;
          unp_ctrl.step = 1'b1;
          lib_nxt       = unp_stat.last;
          lif_nxt       = unp_stat.last && last_byte_r;
          if (unp_stat.last) begin
            if (last_byte_r) begin
              bytes_left_nxt = '0;
              state_nxt      = pfpu_pkg::ST_HDR;
            end else begin
              // next beat may load the shifter while the last digit leaves
              bytes_left_nxt = bytes_left_r - 32'd1;
              in_ready       = 1'b1;
              if (in_valid) begin
                unp_ctrl.load = 1'b1;
                last_byte_nxt = (bytes_left_nxt[31:1] == 31'd0);
              end else begin
                state_nxt = pfpu_pkg::ST_DATA;
              end
            end
          end
        end
      end
      default: state_nxt = pfpu_pkg::ST_HDR;
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
    ow_nxt        = out_load ? cols_r  : ow_r;
    oh_nxt        = out_load ? rows_r  : oh_r;
    od_nxt        = out_load ? depth_r : od_r;
    if (!out_load) begin
      kind_nxt = kind_r;
      pix_nxt  = pix_r;
      lib_nxt  = lib_r;
      lif_nxt  = lif_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfpu_pkg::ST_HDR;
      hdr_idx_r    <= '0;
      rows_r       <= '0;
      cols_r       <= '0;
      depth_r      <= '0;
      bytes_left_r <= '0;
      last_byte_r  <= 1'b0;
      stat_kind_r  <= pfpu_pkg::KIND_PIXEL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      rows_r       <= rows_nxt;
      cols_r       <= cols_nxt;
      depth_r      <= depth_nxt;
      bytes_left_r <= bytes_left_nxt;
      last_byte_r  <= last_byte_nxt;
      stat_kind_r  <= stat_kind_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pix_r  <= pix_nxt;
    lib_r  <= lib_nxt;
    lif_r  <= lif_nxt;
    ow_r   <= ow_nxt;
    oh_r   <= oh_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_pixel_value   = pix_r;
  assign out_last_in_byte  = lib_r;
  assign out_last_in_frame = lif_r;
  assign out_frame_width   = ow_r;
  assign out_frame_height  = oh_r;
  assign out_pixel_depth   = od_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int DIR_N       = 25;
  localparam int RAND_BEATS  = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        lib;
    logic        lif;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] depth;
  } px_beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    px_beat_t   want;
  } dir_row_t;

  localparam px_beat_t NO_BEAT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_pixel_value;
  logic        out_last_in_byte;
  logic        out_last_in_frame;
  logic [15:0] out_frame_width;
  logic [15:0] out_frame_height;
  logic [15:0] out_pixel_depth;

  packed_frame_pixel_unpacker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_pixel_value   (out_pixel_value),
    .out_last_in_byte  (out_last_in_byte),
    .out_last_in_frame (out_last_in_frame),
    .out_frame_width   (out_frame_width),
    .out_frame_height  (out_frame_height),
    .out_pixel_depth   (out_pixel_depth)
  );

  // unpacker state as seen by the predictor
  logic        st_data;
  logic [2:0]  st_pos;
  logic [15:0] st_rows;
  logic [15:0] st_cols;
  logic [15:0] st_depth;
  logic [32:0] st_left;
  px_beat_t    model_out [8];
  int          model_cnt;

  px_beat_t    due_beats [$];
  dir_row_t    dir_tab [DIR_N];
  int          fail_cnt;
  int          beats_sent;
  int          tx_calm;
  int          rx_calm;
  int          hold_cycles;
  int          idle_cnt;
  px_beat_t    got;
  px_beat_t    want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic px_beat_t mk_beat(input logic [1:0] k, input logic [7:0] v,
                                       input logic lb, input logic lf);
    return '{k, v, lb, lf, st_cols, st_rows, st_depth};
  endfunction

  // advance the unpacker state by one stream byte, leave its results in model_out
  function void unpack_byte(input logic [7:0] b);
    logic [63:0] prod;
    logic        legal;
    int          nbits;
    int          npix;
    int          i;
    model_cnt = 0;
    if (!st_data) begin
      case (st_pos)
        pfpu_pkg::HDR_ROWS_HI:  st_rows[15:8]  = b;
        pfpu_pkg::HDR_ROWS_LO:  st_rows[7:0]   = b;
        pfpu_pkg::HDR_COLS_HI:  st_cols[15:8]  = b;
        pfpu_pkg::HDR_COLS_LO:  st_cols[7:0]   = b;
        pfpu_pkg::HDR_DEPTH_HI: st_depth[15:8] = b;
        pfpu_pkg::HDR_DEPTH_LO: st_depth[7:0]  = b;
        default: ;
      endcase
      if (st_pos != pfpu_pkg::HDR_DEPTH_LO) begin
        st_pos = st_pos + 3'd1;
        return;
      end
      st_pos = pfpu_pkg::HDR_ROWS_HI;
      legal = (st_depth == 16'd1) || (st_depth == 16'd2) ||
              (st_depth == 16'd4) || (st_depth == 16'd8);
      if (!legal) begin
        model_out[0] = mk_beat(pfpu_pkg::KIND_BAD_DEPTH, 8'h00, 1'b0, 1'b1);
        model_cnt = 1;
      end else begin
        prod = 64'(st_rows) * 64'(st_cols) * 64'(st_depth);
        st_left = prod[35:3];
        if (st_left == '0) begin
          model_out[0] = mk_beat(pfpu_pkg::KIND_EMPTY, 8'h00, 1'b0, 1'b1);
          model_cnt = 1;
        end else begin
          st_data = 1'b1;
        end
      end
    end else begin
      nbits = int'(st_depth);
      npix  = 8 / nbits;
      // msb-first digits
      for (i = 0; i < npix; i++)
        model_out[i] = mk_beat(pfpu_pkg::KIND_PIXEL,
                               8'((b >> (8 - nbits * (i + 1))) & ((1 << nbits) - 1)),
                               i == npix - 1, (i == npix - 1) && (st_left <= 1));
      model_cnt = npix;
      if (st_left <= 1) begin
        st_data = 1'b0;
        st_pos  = pfpu_pkg::HDR_ROWS_HI;
        st_left = '0;
      end else begin
        st_left = st_left - 33'd1;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input px_beat_t exp_beat);
    int gap;
    int i;
    gap = draw_gap(tx_calm);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    unpack_byte(b);
    if (typed) begin
      due_beats.push_back(exp_beat);
    end else begin
      for (i = 0; i < model_cnt; i++) due_beats.push_back(model_out[i]);
    end
  endtask

  task automatic send_frame();
    logic [15:0] rows;
    logic [15:0] cols;
    logic [15:0] dep;
    int          sel;
    int          nbytes;
    sel = $urandom_range(0, 99);
    nbytes = 0;
    if (sel < 70) begin
      // well-formed small frame
      rows = 16'($urandom_range(1, 4));
      cols = 16'($urandom_range(1, 8));
      dep  = 16'd1 << $urandom_range(0, 3);
      nbytes = int'(rows) * int'(cols) * int'(dep) / 8;
    end else if (sel < 85) begin
      rows = 16'($urandom);
      cols = 16'($urandom);
      do dep = 16'($urandom);
      while (dep == 16'd1 || dep == 16'd2 || dep == 16'd4 || dep == 16'd8);
    end else begin
      // zero-size frame with the other dimension anywhere in range
      rows = 16'($urandom);
      cols = 16'($urandom);
      if ($urandom_range(0, 1) == 0) rows = '0;
      else cols = '0;
      dep = 16'd1 << $urandom_range(0, 3);
    end
    send_byte(rows[15:8], 1'b0, NO_BEAT);
    send_byte(rows[7:0], 1'b0, NO_BEAT);
    send_byte(cols[15:8], 1'b0, NO_BEAT);
    send_byte(cols[7:0], 1'b0, NO_BEAT);
    send_byte(8'($urandom), 1'b0, NO_BEAT);
    send_byte(8'($urandom), 1'b0, NO_BEAT);
    send_byte(dep[15:8], 1'b0, NO_BEAT);
    send_byte(dep[7:0], 1'b0, NO_BEAT);
    repeat (nbytes) send_byte(8'($urandom), 1'b0, NO_BEAT);
  endtask

  // sender goes quiet before waiting for the results
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    int gap;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(rx_calm);
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_pixel_value, out_last_in_byte, out_last_in_frame,
              out_frame_width, out_frame_height, out_pixel_depth};
      if (due_beats.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected beat: kind %0d value %h lib %b lif %b w %h h %h d %h",
                   got.kind, got.value, got.lib, got.lif, got.width, got.height,
                   got.depth);
        fail_cnt++;
      end else begin
        want = due_beats.pop_front();
        if (got !== want) begin
          if (fail_cnt < 10)
            $display({"mismatch exp/got: kind %0d/%0d value %h/%h lib %b/%b lif %b/%b",
                      " w %h/%h h %h/%h d %h/%h"},
                     want.kind, got.kind, want.value, got.value, want.lib, got.lib,
                     want.lif, got.lif, want.width, got.width, want.height, got.height,
                     want.depth, got.depth);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("[packed_frame_pixel_unpacker] ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    fail_cnt     = 0;
    beats_sent   = 0;
    tx_calm      = 0;
    rx_calm      = 0;
    hold_cycles  = 0;
    idle_cnt     = 0;
    st_data      = 1'b0;
    st_pos       = pfpu_pkg::HDR_ROWS_HI;
    st_rows      = '0;
    st_cols      = '0;
    st_depth     = '0;
    st_left      = '0;

    dir_tab = '{
      // all-ones header: illegal depth, sizes at their maximum
      '{8'hFF, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, '{pfpu_pkg::KIND_BAD_DEPTH, 8'h00, 1'b0, 1'b1,
                       16'hFFFF, 16'hFFFF, 16'hFFFF}},
      // 1x3 at 2 bpp: 6 bits truncate to zero data bytes
      '{8'h00, 1'b0, NO_BEAT}, '{8'h01, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT}, '{8'h03, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'h02, 1'b1, '{pfpu_pkg::KIND_EMPTY, 8'h00, 1'b0, 1'b1,
                       16'h0003, 16'h0001, 16'h0002}},
      // 1x2 at 4 bpp, junk in the ignored bytes, one data byte
      '{8'h00, 1'b0, NO_BEAT}, '{8'h01, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT}, '{8'h02, 1'b0, NO_BEAT},
      '{8'hA5, 1'b0, NO_BEAT}, '{8'h5A, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT}, '{8'h04, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    i = 0;
    while (beats_sent < DIR_N + RAND_BEATS) begin
      if (i == 3) wait_drained();
      if (i == 6) hold_cycles = LONG_HOLD;
      send_frame();
      i++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) $display("[packed_frame_pixel_unpacker] OK");
    else $display("[packed_frame_pixel_unpacker] ERROR");
    $finish;
  end

endmodule
